// ===== rtl/wfg_pkg.sv =====
// shared types and constants of the wait-for graph deadlock detector
package wfg_pkg;

  localparam int NODES_DEF         = 16;
  localparam int MAX_OUT_EDGES_DEF = 16;
  localparam int PCOUNT_W          = 5;
  localparam int NODE_FIELD_W      = 4;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DETECT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_REJECTED    = 2'd1,
    ST_NO_DEADLOCK = 2'd2,
    ST_CYCLE       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_ROOT,
    S_PUSH_WAIT,
    S_STEP,
    S_EDGE_WAIT,
    S_POP_WAIT,
    S_SCAN,
    S_EMIT,
    S_EMIT_TOP,
    S_EMIT_LAST
  } state_t;

endpackage

// ===== rtl/wait_for_graph_deadlock_detect.sv =====
// top level: wait-for graph store, depth-first cycle search and result sequencer
//
//  channel   signals                                 transfer when
//  input     start busy action from_node to_node     start && !busy
//  config    cfg_valid cfg_ready cfg_data            cfg_valid && cfg_ready
//  result    result_strobe status process last       result_strobe (one cycle)
//
// add edge: busy while in S_ADD, result strobed in the cycle after. clear: no busy cycle, no result.
// detect: each root tried passes S_ROOT, each edge examined S_STEP and S_EDGE_WAIT, each push
// S_PUSH_WAIT, each pop S_STEP and S_POP_WAIT, then a stack scan and the emit states that report
// the cycle's nodes; the worst case is set by the single read port of the edge ram.
// reset is synchronous; edge counts clear by valid bits.
// results leave on a strobe and cannot be stalled by the receiver.
module wait_for_graph_deadlock_detect
  import wfg_pkg::*;
#(
  parameter int NODES         = NODES_DEF,
  parameter int MAX_OUT_EDGES = MAX_OUT_EDGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              action,
  input  logic [NODE_FIELD_W-1:0] from_node,
  input  logic [NODE_FIELD_W-1:0] to_node,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [PCOUNT_W-1:0]     cfg_data,
  output logic                    result_strobe,
  output logic [1:0]              status,
  output logic [NODE_FIELD_W-1:0] process,
  output logic                    last
);

  localparam int NW   = $clog2(NODES);
  localparam int SW   = $clog2(NODES + 1);
  localparam int KW   = (SW > PCOUNT_W) ? SW : PCOUNT_W;
  localparam int CW   = $clog2(MAX_OUT_EDGES + 1);
  localparam int EW   = (MAX_OUT_EDGES > 1) ? $clog2(MAX_OUT_EDGES) : 1;
  localparam int EDEP = NODES * MAX_OUT_EDGES;
  localparam int AEW  = $clog2(EDEP);
  localparam int SEW  = NW + 2 * CW;

  state_t state, state_next;

  logic [PCOUNT_W-1:0] process_count;
  logic [KW-1:0]       count;

  logic [NW-1:0] from_n, from_n_next;
  logic [NW-1:0] to_n, to_n_next;
  logic          add_ok, add_ok_next;
  logic [KW-1:0] root, root_next;
  logic [NW-1:0] top_node, top_node_next;
  logic [CW-1:0] top_next, top_next_next;
  logic [CW-1:0] top_cnt, top_cnt_next;
  logic [SW-1:0] sp, sp_next;
  logic [NW-1:0] pos, pos_next;
  logic [NW-1:0] v_node, v_node_next;
  logic [NODES-1:0] visited, visited_next;
  logic [NODES-1:0] on_stack, on_stack_next;
  logic [NODES-1:0] cnt_valid, cnt_valid_next;

  logic                    strobe_next;
  logic [1:0]              status_next;
  logic [NODE_FIELD_W-1:0] process_next;
  logic                    last_next;

  // edge list ram
  logic           edge_we;
  logic [NW-1:0]  edge_node;
  logic [EW-1:0]  edge_idx;
  logic [AEW-1:0] edge_addr;
  logic [NW-1:0]  edge_rdata;

  // edge count ram
  logic          cnt_we;
  logic [NW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [NW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rdata;

  // search stack ram, entry is node, next edge index, edge count
  logic           stk_we;
  logic [NW-1:0]  stk_waddr;
  logic [SEW-1:0] stk_wdata;
  logic [NW-1:0]  stk_raddr;
  logic [SEW-1:0] stk_rdata;
  logic [NW-1:0]  stk_rd_node;

  logic [KW-1:0] from_k, to_k;
  logic [CW-1:0] cnt_cur;
  logic [SW-1:0] sp_m1, sp_m2, pos_p1;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign count = (KW'(process_count) > KW'(NODES)) ? KW'(NODES) : KW'(process_count);

  assign from_k      = KW'(from_node);
  assign to_k        = KW'(to_node);
  assign cnt_cur     = cnt_valid[from_n] ? cnt_rdata : '0;
  assign sp_m1       = sp - SW'(1);
  assign sp_m2       = sp - SW'(2);
  assign pos_p1      = SW'(pos) + SW'(1);
  assign stk_rd_node = stk_rdata[SEW-1 -: NW];
  assign edge_addr   = AEW'(edge_node) * AEW'(MAX_OUT_EDGES) + AEW'(edge_idx);

  wfg_ram #(.WIDTH(NW), .DEPTH(EDEP)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_addr),
    .wdata (to_n),
    .raddr (edge_addr),
    .rdata (edge_rdata)
  );

  wfg_ram #(.WIDTH(CW), .DEPTH(NODES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  wfg_ram #(.WIDTH(SEW), .DEPTH(NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= PCOUNT_RST;
      cnt_valid     <= '0;
      visited       <= '0;
      on_stack      <= '0;
      result_strobe <= 1'b0;
      root          <= '0;
      sp            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        process_count <= cfg_data;
      end
      cnt_valid     <= cnt_valid_next;
      visited       <= visited_next;
      on_stack      <= on_stack_next;
      result_strobe <= strobe_next;
      root          <= root_next;
      sp            <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    from_n   <= from_n_next;
    to_n     <= to_n_next;
    add_ok   <= add_ok_next;
    top_node <= top_node_next;
    top_next <= top_next_next;
    top_cnt  <= top_cnt_next;
    pos      <= pos_next;
    v_node   <= v_node_next;
    status   <= status_next;
    process  <= process_next;
    last     <= last_next;
  end

  always_comb begin
    state_next     = state;
    from_n_next    = from_n;
    to_n_next      = to_n;
    add_ok_next    = add_ok;
    root_next      = root;
    top_node_next  = top_node;
    top_next_next  = top_next;
    top_cnt_next   = top_cnt;
    sp_next        = sp;
    pos_next       = pos;
    v_node_next    = v_node;
    visited_next   = visited;
    on_stack_next  = on_stack;
    cnt_valid_next = cnt_valid;
    strobe_next    = 1'b0;
    status_next    = status;
    process_next   = process;
    last_next      = 1'b0;
    edge_we        = 1'b0;
    edge_node      = top_node;
    edge_idx       = EW'(top_next);
    cnt_we         = 1'b0;
    cnt_waddr      = from_n;
    cnt_wdata      = cnt_cur + CW'(1);
    cnt_raddr      = top_node;
    stk_we         = 1'b0;
    stk_waddr      = sp_m1[NW-1:0];
    stk_wdata      = {top_node, top_next, top_cnt};
    stk_raddr      = pos;

    case (state)
      S_IDLE: begin
        cnt_raddr = NW'(from_k);
        if (start) begin
          from_n_next = NW'(from_k);
          to_n_next   = NW'(to_k);
          add_ok_next = (from_k < count) && (to_k < count);
          case (action_t'(action))
            ACT_ADD: begin
              state_next = S_ADD;
            end
            ACT_DETECT: begin
              visited_next  = '0;
              on_stack_next = '0;
              root_next     = '0;
              state_next    = S_ROOT;
            end
            ACT_CLEAR: begin
              cnt_valid_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD: begin
        edge_node    = from_n;
        edge_idx     = EW'(cnt_cur);
        strobe_next  = 1'b1;
        last_next    = 1'b1;
        process_next = '0;
        if (add_ok && (cnt_cur < CW'(MAX_OUT_EDGES))) begin
          edge_we                = 1'b1;
          cnt_we                 = 1'b1;
          cnt_valid_next[from_n] = 1'b1;
          status_next            = ST_ACCEPTED;
        end else begin
          status_next = ST_REJECTED;
        end
        state_next = S_IDLE;
      end

      S_ROOT: begin
        cnt_raddr = NW'(root);
        if (root >= count) begin
          strobe_next  = 1'b1;
          last_next    = 1'b1;
          status_next  = ST_NO_DEADLOCK;
          process_next = '0;
          state_next   = S_IDLE;
        end else if (visited[NW'(root)]) begin
          root_next = root + KW'(1);
        end else begin
          visited_next[NW'(root)]  = 1'b1;
          on_stack_next[NW'(root)] = 1'b1;
          top_node_next            = NW'(root);
          top_next_next            = '0;
          sp_next                  = SW'(1);
          state_next               = S_PUSH_WAIT;
        end
      end

      S_PUSH_WAIT: begin
        top_cnt_next = cnt_valid[top_node] ? cnt_rdata : '0;
        state_next   = S_STEP;
      end

      S_STEP: begin
        stk_raddr = sp_m2[NW-1:0];
        if (top_next >= top_cnt) begin
          on_stack_next[top_node] = 1'b0;
          if (sp == SW'(1)) begin
            root_next  = root + KW'(1);
            state_next = S_ROOT;
          end else begin
            sp_next    = sp_m1;
            state_next = S_POP_WAIT;
          end
        end else begin
          top_next_next = top_next + CW'(1);
          state_next    = S_EDGE_WAIT;
        end
      end

      S_POP_WAIT: begin
        {top_node_next, top_next_next, top_cnt_next} = stk_rdata;
        state_next = S_STEP;
      end

      S_EDGE_WAIT: begin
        cnt_raddr = edge_rdata;
        stk_raddr = sp_m2[NW-1:0];
        state_next = S_STEP;
        if (KW'(edge_rdata) < count) begin
          if (!visited[edge_rdata]) begin
            // push unless the depth limit is reached; otherwise skip this edge
            if (sp < SW'(NODES)) begin
              stk_we                    = 1'b1;
              visited_next[edge_rdata]  = 1'b1;
              on_stack_next[edge_rdata] = 1'b1;
              top_node_next             = edge_rdata;
              top_next_next             = '0;
              sp_next                   = sp + SW'(1);
              state_next                = S_PUSH_WAIT;
            end
          end else if (on_stack[edge_rdata]) begin
            v_node_next = edge_rdata;
            if (edge_rdata == top_node) begin
              // self-loop reports the single node
              strobe_next  = 1'b1;
              last_next    = 1'b1;
              status_next  = ST_CYCLE;
              process_next = NODE_FIELD_W'(KW'(edge_rdata));
              state_next   = S_IDLE;
            end else begin
              pos_next   = sp_m2[NW-1:0];
              state_next = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // walk down the stack to the back edge target
        if (stk_rd_node == v_node) begin
          if (pos_p1 == sp_m1) begin
            state_next = S_EMIT_TOP;
          end else begin
            stk_raddr  = pos_p1[NW-1:0];
            pos_next   = pos_p1[NW-1:0];
            state_next = S_EMIT;
          end
        end else begin
          stk_raddr = pos - NW'(1);
          pos_next  = pos - NW'(1);
        end
      end

      S_EMIT: begin
        strobe_next  = 1'b1;
        status_next  = ST_CYCLE;
        process_next = NODE_FIELD_W'(KW'(stk_rd_node));
        if (pos_p1 == sp_m1) begin
          state_next = S_EMIT_TOP;
        end else begin
          stk_raddr = pos_p1[NW-1:0];
          pos_next  = pos_p1[NW-1:0];
        end
      end

      S_EMIT_TOP: begin
        strobe_next  = 1'b1;
        status_next  = ST_CYCLE;
        process_next = NODE_FIELD_W'(KW'(top_node));
        state_next   = S_EMIT_LAST;
      end

      S_EMIT_LAST: begin
        strobe_next  = 1'b1;
        last_next    = 1'b1;
        status_next  = ST_CYCLE;
        process_next = NODE_FIELD_W'(KW'(v_node));
        state_next   = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wfg_ram.sv =====
// generic single-write, single-read ram with registered read data
module wfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/wait_for_graph_deadlock_detect_tb.sv =====
// testbench for the wait-for graph deadlock detector: random graphs, cycle search and checks
`timescale 1ns / 100ps

module wait_for_graph_deadlock_detect_tb;
  import wfg_pkg::*;

  // action code with no meaning, the block ignores it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    status_t     st;
    logic [3:0]  member;
    logic        is_last;
  } wfg_result_t;

  class wfg_scoreboard;
    logic [3:0]  adj [NODES_DEF][MAX_OUT_EDGES_DEF];
    int unsigned deg [NODES_DEF];
    int unsigned pcount = 32'(PCOUNT_RST);
    int unsigned cycle_nodes [$];
    wfg_result_t pending [$];
    int          errors;
    int          results_checked;
    int          deadlocks_found;

    function int unsigned active_count();
      return (pcount > NODES_DEF) ? NODES_DEF : pcount;
    endfunction

    function void set_count(logic [PCOUNT_W-1:0] v);
      pcount = 32'(v);
    endfunction

    function void expect_result(status_t st, logic [3:0] member, logic is_last);
      wfg_result_t r;
      r.st      = st;
      r.member  = member;
      r.is_last = is_last;
      pending.insert(pending.size(), r);
    endfunction

    // depth-first search from node 0 upward, stops at the first back edge
    function void find_cycle();
      int unsigned eff;
      bit          seen [NODES_DEF];
      bit          onstk [NODES_DEF];
      int unsigned par [NODES_DEF];
      int unsigned snode [NODES_DEF];
      int unsigned snext [NODES_DEF];
      int unsigned walk [NODES_DEF];
      int unsigned u, idx, v, cur, r;
      int          sp, n, i;
      cycle_nodes.delete();
      eff = active_count();
      for (i = 0; i < NODES_DEF; i++) begin
        seen[i]  = 1'b0;
        onstk[i] = 1'b0;
        par[i]   = 0;
      end
      for (r = 0; r < eff; r++) begin
        if (seen[r]) continue;
        seen[r]  = 1'b1;
        onstk[r] = 1'b1;
        snode[0] = r;
        snext[0] = 0;
        sp = 1;
        while (sp > 0) begin
          u   = snode[sp-1];
          idx = snext[sp-1];
          if (idx >= deg[u] || idx >= MAX_OUT_EDGES_DEF) begin
            onstk[u] = 1'b0;
            sp--;
            continue;
          end
          snext[sp-1] = idx + 1;
          v = adj[u][idx];
          // edges into nodes beyond the current count are skipped
          if (v >= eff) continue;
          if (!seen[v]) begin
            if (sp >= NODES_DEF) continue;
            par[v]    = u;
            seen[v]   = 1'b1;
            onstk[v]  = 1'b1;
            snode[sp] = v;
            snext[sp] = 0;
            sp++;
          end else if (onstk[v]) begin
            n   = 0;
            cur = u;
            while (cur != v && n < NODES_DEF - 1) begin
              walk[n] = cur;
              n++;
              cur = par[cur] % NODES_DEF;
            end
            for (i = n - 1; i >= 0; i--) cycle_nodes.insert(cycle_nodes.size(), walk[i]);
            cycle_nodes.insert(cycle_nodes.size(), v);
            return;
          end
        end
      end
    endfunction

    function void note_item(logic [1:0] act, logic [3:0] from_n, logic [3:0] to_n);
      int unsigned eff;
      int          k;
      eff = active_count();
      case (act)
        ACT_ADD: begin
          if (from_n >= eff || to_n >= eff || deg[from_n] >= MAX_OUT_EDGES_DEF) begin
            expect_result(ST_REJECTED, 4'd0, 1'b1);
          end else begin
            adj[from_n][deg[from_n]] = to_n;
            deg[from_n]++;
            expect_result(ST_ACCEPTED, 4'd0, 1'b1);
          end
        end
        ACT_DETECT: begin
          find_cycle();
          if (cycle_nodes.size() == 0) begin
            expect_result(ST_NO_DEADLOCK, 4'd0, 1'b1);
          end else begin
            deadlocks_found++;
            for (k = 0; k < cycle_nodes.size(); k++)
              expect_result(ST_CYCLE, cycle_nodes[k][3:0], k == cycle_nodes.size() - 1);
          end
        end
        ACT_CLEAR: begin
          for (k = 0; k < NODES_DEF; k++) deg[k] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [3:0] member, logic is_last);
      wfg_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d process %0d last %0b", st, member, is_last);
        errors++;
        return;
      end
      e = pending.pop_front();
      results_checked++;
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (member !== e.member) begin
        $error("process: expected %0d, got %0d", e.member, member);
        errors++;
      end
      if (is_last !== e.is_last) begin
        $error("last: expected %0b, got %0b", e.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              action;
  logic [NODE_FIELD_W-1:0] from_node;
  logic [NODE_FIELD_W-1:0] to_node;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [PCOUNT_W-1:0]     cfg_data;
  logic                    res_strobe;
  logic [1:0]              res_status;
  logic [NODE_FIELD_W-1:0] res_node;
  logic                    res_last;

  wfg_scoreboard sb;
  int            items_sent;
  int            count_writes;

  wait_for_graph_deadlock_detect uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .from_node     (from_node),
    .to_node       (to_node),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (res_strobe),
    .status        (res_status),
    .process       (res_node),
    .last          (res_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_strobe) sb.check_result(res_status, res_node, res_last);
  end

  // start stays high into the next item unless idle cycles are drawn
  task automatic send_item(input logic [1:0] act, input logic [3:0] from_n,
                           input logic [3:0] to_n);
    bit idle_on;
    idle_on = !(items_sent >= 150 && items_sent < 230);
    while (idle_on && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    from_node <= from_n;
    to_node   <= to_n;
    do @(posedge clk); while (busy);
    sb.note_item(act, from_n, to_n);
    if (act == ACT_ADD || act == ACT_DETECT || act == ACT_CLEAR) items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [PCOUNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(v);
    count_writes++;
  endtask

  // mostly in range, now and then any 4-bit index
  function automatic logic [3:0] pick_node();
    int unsigned eff;
    eff = sb.active_count();
    if (eff == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, eff - 1));
  endfunction

  task automatic run_scenario();
    int          kind, n, i;
    logic [3:0]  ring [5];
    logic [3:0]  hub;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // random graph, often with a planted ring, then a search
      if ($urandom_range(0, 9) < 7) send_item(ACT_CLEAR, 4'($urandom_range(0, 15)), 4'd0);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) send_item(ACT_ADD, pick_node(), pick_node());
      if ($urandom_range(0, 2) != 0) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) ring[i] = pick_node();
        for (i = 0; i < n; i++) send_item(ACT_ADD, ring[i], ring[(i + 1) % n]);
      end
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) send_item(ACT_ADD, pick_node(), pick_node());
      send_item(ACT_DETECT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else if (kind < 62) begin
      // fill one edge list up to or past its limit
      hub = pick_node();
      n = $urandom_range(16, 18);
      for (i = 0; i < n; i++) send_item(ACT_ADD, hub, pick_node());
      send_item(ACT_DETECT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        send_item(ACT_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      send_item(ACT_DETECT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
        send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_phase(input logic [PCOUNT_W-1:0] cnt, input int quota);
    int first;
    write_count(cnt);
    // search the graph left from the previous setting before touching it
    send_item(ACT_DETECT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    first = items_sent;
    while (items_sent - first < quota) run_scenario();
  endtask

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [PCOUNT_W-1:0] settings [9];
    int                  p, guard;
    sb        = new;
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    action    = ACT_ADD;
    from_node = '0;
    to_node   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    settings  = '{5'd5, 5'd0, 5'd1, 5'd31, 5'd9, 5'd2, 5'd17, 5'd16, 5'd12};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_count(5'd16);
    send_item(ACT_DETECT, 4'd0, 4'd0);
    send_item(ACT_ADD, 4'd0, 4'd15);
    send_item(ACT_ADD, 4'd15, 4'd0);
    send_item(ACT_DETECT, 4'd15, 4'd15);
    send_item(ACT_UNUSED, 4'd15, 4'd15);
    send_item(ACT_CLEAR, 4'd0, 4'd0);
    send_item(ACT_ADD, 4'd7, 4'd7);
    send_item(ACT_DETECT, 4'd0, 4'd0);
    send_item(ACT_CLEAR, 4'd0, 4'd0);
    send_item(ACT_ADD, 4'd0, 4'd1);
    send_item(ACT_ADD, 4'd1, 4'd2);
    send_item(ACT_ADD, 4'd2, 4'd3);
    send_item(ACT_ADD, 4'd3, 4'd1);
    send_item(ACT_ADD, 4'd4, 4'd15);
    send_item(ACT_DETECT, 4'd0, 4'd0);
    send_item(ACT_CLEAR, 4'd0, 4'd0);
    send_item(ACT_ADD, 4'd0, 4'd1);
    send_item(ACT_ADD, 4'd0, 4'd2);
    send_item(ACT_ADD, 4'd1, 4'd2);
    send_item(ACT_DETECT, 4'd0, 4'd0);
    send_item(ACT_ADD, 4'd15, 4'd15);
    send_item(ACT_ADD, 4'd14, 4'd13);

    for (p = 0; p < 9; p++) run_phase(settings[p], 32);

    start <= 1'b0;
    guard = 0;
    while ((sb.pending.size() != 0 || busy) && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end

    $display("covered %0d transfers under %0d process counts, %0d results checked",
             items_sent, count_writes, sb.results_checked);
    $display("searches that found a deadlock: %0d", sb.deadlocks_found);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wfg_pkg.sv
rtl/wfg_ram.sv
rtl/wait_for_graph_deadlock_detect.sv
tb/wait_for_graph_deadlock_detect_tb.sv
